// ===== sv/l4s_pkg.sv =====
// Shared types and constants for the four-sector robust range block.
// No dependencies; every other file imports this package.
package l4s_pkg;

  localparam int RANK_KEPT_DEF = 3;
  localparam int NSECT         = 4;
  localparam int CFG_IDX_W     = 3;

  localparam logic [15:0] FULL_TURN = 16'd36000;
  localparam logic [15:0] HALF_TURN = 16'd18000;
  localparam logic [14:0] HALF_MIN  = 15'd100;
  localparam logic [14:0] HALF_MAX  = 15'd18000;

  // Sector centre offsets from the front centre: front, rear, left, right
  localparam logic [15:0] SECT_OFFS [NSECT] = '{16'd0, 16'd18000, 16'd9000, 16'd27000};

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_START = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_END   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_MAX   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRONT_CTR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH = 3'd5;

  typedef struct packed {
    logic [15:0] point_angle;
    logic [15:0] point_distance;
    logic        scan_last;
  } point_t;

  typedef struct packed {
    logic [15:0] front_range;
    logic [15:0] rear_range;
    logic [15:0] left_range;
    logic [15:0] right_range;
    logic [3:0]  sector_found;
    logic [31:0] scan_number;
  } result_t;

  typedef struct packed {
    logic [15:0] min_valid_distance;
    logic [15:0] mask_start_angle;
    logic [15:0] mask_end_angle;
    logic [15:0] mask_max_distance;
    logic [15:0] front_center_angle;
    logic [14:0] sector_half_width;
  } cfg_t;

  typedef struct packed {
    logic ins;
    logic clr;
  } rank_ctl_t;

endpackage

// ===== sv/l4s_filter.sv =====
// Point filter and sector membership test.
// Depends on l4s_pkg for the point and configuration types.
module l4s_filter import l4s_pkg::*; (
  input  cfg_t             cfg,
  input  point_t           pt,
  output logic [NSECT-1:0] hit
);

  logic              drop;
  logic [15:0]       ang_m;
  logic [15:0]       fc_m;
  logic [14:0]       half;
  logic [16:0]       ctr   [NSECT];
  logic signed [17:0] dlt  [NSECT];
  logic [17:0]       mag   [NSECT];

  always_comb begin
    drop = (pt.point_distance == 16'd0) ||
           (pt.point_distance < cfg.min_valid_distance) ||
           ((pt.point_angle >= cfg.mask_start_angle) &&
            (pt.point_angle <= cfg.mask_end_angle) &&
            (pt.point_distance <= cfg.mask_max_distance));

    ang_m = (pt.point_angle >= FULL_TURN) ? pt.point_angle - FULL_TURN : pt.point_angle;
    fc_m  = (cfg.front_center_angle >= FULL_TURN) ?
            cfg.front_center_angle - FULL_TURN : cfg.front_center_angle;

    // clamp half width to one to a hundred and eighty degrees
    if (cfg.sector_half_width < HALF_MIN) begin
      half = HALF_MIN;
    end else if (cfg.sector_half_width > HALF_MAX) begin
      half = HALF_MAX;
    end else begin
      half = cfg.sector_half_width;
    end

    for (int s = 0; s < NSECT; s++) begin
      ctr[s] = {1'b0, fc_m} + {1'b0, SECT_OFFS[s]};
      if (ctr[s] >= {1'b0, FULL_TURN}) begin
        ctr[s] = ctr[s] - {1'b0, FULL_TURN};
      end
      // wrap the delta into half-open range -180..+180 degrees
      dlt[s] = $signed({2'b00, ang_m}) - $signed({1'b0, ctr[s]});
      if (dlt[s] >= $signed({2'b00, HALF_TURN})) begin
        dlt[s] = dlt[s] - $signed({2'b00, FULL_TURN});
      end else if (dlt[s] < -$signed({2'b00, HALF_TURN})) begin
        dlt[s] = dlt[s] + $signed({2'b00, FULL_TURN});
      end
      mag[s] = dlt[s][17] ? 18'(-dlt[s]) : 18'(dlt[s]);
      hit[s] = !drop && (mag[s] <= {3'b000, half});
    end
  end

endmodule

// ===== sv/l4s_rank.sv =====
// Sorted list of the smallest distances seen by one sector in a scan.
// Depends on l4s_pkg for the control struct and default rank depth.
module l4s_rank import l4s_pkg::*; #(
  parameter int RANK = RANK_KEPT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  rank_ctl_t   ctl,
  input  logic [15:0] range_in,
  output logic        found,
  output logic [15:0] robust
);

  localparam int FW = $clog2(RANK + 1);
  localparam int IW = (RANK > 1) ? $clog2(RANK) : 1;

  logic [15:0]   ranks_r   [RANK];
  logic [15:0]   ranks_nxt [RANK];
  logic [FW-1:0] fill_r, fill_nxt, pos;
  logic [IW-1:0] sel;

  always_comb begin
    // insertion point: entries held that are at or below the new distance
    pos = '0;
    for (int i = 0; i < RANK; i++) begin
      if ((FW'(i) < fill_r) && (ranks_r[i] <= range_in)) begin
        pos = pos + FW'(1);
      end
    end
    for (int i = 0; i < RANK; i++) begin
      if (!ctl.ins || (FW'(i) < pos)) begin
        ranks_nxt[i] = ranks_r[i];
      end else if (FW'(i) == pos) begin
        ranks_nxt[i] = range_in;
      end else begin
        ranks_nxt[i] = ranks_r[(i > 0) ? i - 1 : 0];
      end
    end
    fill_nxt = (ctl.ins && (fill_r != FW'(RANK))) ? fill_r + FW'(1) : fill_r;
    found    = (fill_nxt != '0);
    sel      = IW'(fill_nxt - FW'(1));
    robust   = found ? ranks_nxt[sel] : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= ctl.clr ? '0 : fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      ranks_r <= ranks_nxt;
    end
  end

endmodule

// ===== sv/lidar_four_sector_robust_range.sv =====
// Top level of the four-sector robust lidar range block.
// Depends on l4s_pkg, l4s_filter and l4s_rank.
//
//  channel  direction  handshake             payload
//  in_      input      in_valid / in_stall   point_t  (angle, distance, last-of-scan)
//  out_     output     out_valid / out_stall result_t (four ranges, found, scan no.)
//  cfg_     input      cfg_valid / cfg_ready index 0..5, 16-bit data
//
// One point per cycle, sustained, while in_stall stays low. A point is
// registered on acceptance, then filtered, binned and inserted into the
// sector lists from that register; a last-of-scan point loads the result
// register in that same cycle, unless an earlier result is still held.
// Reset (rst_n low, synchronous) sets half width 3000, clears other registers,
// fill counts, scan count and both valid flags. The distance lists need no reset.
// The input side stalls only when a last-of-scan point waits in the input
// register while an earlier result is still held by out_stall.
module lidar_four_sector_robust_range import l4s_pkg::*; #(
  parameter int RANK_KEPT = RANK_KEPT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  point_t               in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output result_t              out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  cfg_t             cfg_r;
  point_t           s1_r;
  logic             s1_v_r;
  logic             s1_hold, s1_fire, in_acc, scan_end;
  logic             out_v_r;
  result_t          out_r;
  logic [31:0]      scan_cnt_r;
  logic [NSECT-1:0] hit;
  logic [NSECT-1:0] found;
  logic [15:0]      robust [NSECT];
  rank_ctl_t        ctl    [NSECT];

  // Register file: writes are always taken, unknown indexes are ignored
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_valid_distance <= 16'd0;
      cfg_r.mask_start_angle   <= 16'd0;
      cfg_r.mask_end_angle     <= 16'd0;
      cfg_r.mask_max_distance  <= 16'd0;
      cfg_r.front_center_angle <= 16'd0;
      cfg_r.sector_half_width  <= 15'd3000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MIN_DIST:   cfg_r.min_valid_distance <= cfg_data;
        REG_MASK_START: cfg_r.mask_start_angle   <= cfg_data;
        REG_MASK_END:   cfg_r.mask_end_angle     <= cfg_data;
        REG_MASK_MAX:   cfg_r.mask_max_distance  <= cfg_data;
        REG_FRONT_CTR:  cfg_r.front_center_angle <= cfg_data;
        REG_HALF_WIDTH: cfg_r.sector_half_width  <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Hold a last-of-scan point while the previous result is still unclaimed
  assign s1_hold  = s1_r.scan_last && out_v_r && out_stall;
  assign s1_fire  = s1_v_r && !s1_hold;
  assign in_stall = s1_v_r && s1_hold;
  assign in_acc   = in_valid && !in_stall;
  assign scan_end = s1_fire && s1_r.scan_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_fire) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= in_data;
    end
  end

  l4s_filter u_filter (
    .cfg (cfg_r),
    .pt  (s1_r),
    .hit (hit)
  );

  for (genvar s = 0; s < NSECT; s++) begin : g_sect
    assign ctl[s].ins = s1_fire && hit[s];
    assign ctl[s].clr = scan_end;

    l4s_rank #(.RANK(RANK_KEPT)) u_rank (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl[s]),
      .range_in (s1_r.point_distance),
      .found    (found[s]),
      .robust   (robust[s])
    );
  end

  // Advance the scan count and load the result at the end of each scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_cnt_r <= 32'd0;
      out_v_r    <= 1'b0;
    end else begin
      if (scan_end) begin
        scan_cnt_r <= scan_cnt_r + 32'd1;
        out_v_r    <= 1'b1;
      end else if (out_v_r && !out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_end) begin
      out_r.front_range  <= robust[0];
      out_r.rear_range   <= robust[1];
      out_r.left_range   <= robust[2];
      out_r.right_range  <= robust[3];
      out_r.sector_found <= found;
      out_r.scan_number  <= scan_cnt_r + 32'd1;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// ===== sv/l4s_checker.sv =====
// Port-level checks for the four-sector robust range block.
// Depends on l4s_pkg; bound to lidar_four_sector_robust_range below.
module l4s_checker import l4s_pkg::*; (
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_stall,
  input point_t  in_data,
  input logic    out_valid,
  input logic    out_stall,
  input result_t out_data
);

  logic [31:0] last_scan_r;
  logic [2:0]  pend_r;
  logic        in_end, out_fire;

  assign in_end   = in_valid && !in_stall && in_data.scan_last;
  assign out_fire = out_valid && !out_stall;

  // Track scans taken but not yet delivered, and the last scan number seen
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_scan_r <= 32'd0;
      pend_r      <= 3'd0;
    end else begin
      if (out_fire) begin
        last_scan_r <= out_data.scan_number;
      end
      pend_r <= pend_r + {2'b00, in_end} - {2'b00, out_fire};
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_scan_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire |-> out_data.scan_number == last_scan_r + 32'd1)
    else $error("scan number skipped or repeated");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 3'd0)
    else $error("result without a completed scan");

  a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.sector_found[0] || out_data.front_range == 16'd0) &&
                  (out_data.sector_found[1] || out_data.rear_range  == 16'd0) &&
                  (out_data.sector_found[2] || out_data.left_range  == 16'd0) &&
                  (out_data.sector_found[3] || out_data.right_range == 16'd0))
    else $error("range given for an empty sector");

endmodule

bind lidar_four_sector_robust_range l4s_checker u_l4s_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/sv/l4s_range_checker.sv =====
// Scoreboard for the four-sector robust range block: it watches the point,
// result and register channels, predicts each scan result and compares it.
// Depends on l4s_pkg for the payload types, register indexes and constants.
module l4s_range_checker import l4s_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  point_t               in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  result_t              out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  output int                   mismatches,
  output int                   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RANK             = RANK_KEPT_DEF;
  localparam logic [14:0] HALF_WIDTH_RESET = 15'd3000;
  localparam int          FRONT            = 0;
  localparam int          REAR             = 1;
  localparam int          LEFT             = 2;
  localparam int          RIGHT            = 3;

  cfg_t        regs;
  logic [15:0] nearest [NSECT][RANK];
  int unsigned held [NSECT];
  logic [31:0] scans_done;
  result_t     due_results [$];
  int          errors_seen = 0;

  function automatic bit within_sector(int unsigned ang, int unsigned ctr, int unsigned half);
    int unsigned wrapped;
    int unsigned mag;
    wrapped = (ang + FULL_TURN + HALF_TURN - ctr) % FULL_TURN;
    mag = (wrapped >= HALF_TURN) ? wrapped - HALF_TURN : HALF_TURN - wrapped;
    return mag <= half;
  endfunction

  // Keep the sector's smallest ranges sorted, nearest first
  task automatic keep_nearest(int s, logic [15:0] d);
    int slot;
    if (held[s] >= RANK) begin
      if (d >= nearest[s][RANK-1]) return;
      slot = RANK - 1;
    end else begin
      slot = held[s];
      held[s]++;
    end
    while (slot > 0 && nearest[s][slot-1] > d) begin
      nearest[s][slot] = nearest[s][slot-1];
      slot--;
    end
    nearest[s][slot] = d;
  endtask

  task automatic bin_point(point_t p);
    logic        drop;
    int unsigned half;
    int unsigned ang;
    int unsigned front_ctr;
    int unsigned ctr;
    logic [15:0] robust [NSECT];
    logic [3:0]  found;
    result_t     r;
    drop = (p.point_distance == 16'd0) || (p.point_distance < regs.min_valid_distance);
    if (!drop && p.point_angle >= regs.mask_start_angle &&
        p.point_angle <= regs.mask_end_angle &&
        p.point_distance <= regs.mask_max_distance)
      drop = 1'b1;
    if (!drop) begin
      half = regs.sector_half_width;
      if (half < HALF_MIN) half = HALF_MIN;
      if (half > HALF_MAX) half = HALF_MAX;
      ang       = p.point_angle % FULL_TURN;
      front_ctr = regs.front_center_angle % FULL_TURN;
      for (int s = 0; s < NSECT; s++) begin
        ctr = (front_ctr + SECT_OFFS[s]) % FULL_TURN;
        if (within_sector(ang, ctr, half)) keep_nearest(s, p.point_distance);
      end
    end
    if (p.scan_last) begin
      found = '0;
      for (int s = 0; s < NSECT; s++) begin
        if (held[s] > 0) begin
          robust[s] = nearest[s][held[s]-1];
          found[s]  = 1'b1;
        end else begin
          robust[s] = '0;
        end
        held[s] = 0;
      end
      scans_done     = scans_done + 32'd1;
      r.front_range  = robust[FRONT];
      r.rear_range   = robust[REAR];
      r.left_range   = robust[LEFT];
      r.right_range  = robust[RIGHT];
      r.sector_found = found;
      r.scan_number  = scans_done;
      due_results.insert(due_results.size(), r);
    end
  endtask

  function automatic int field_differs(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      regs                   = '0;
      regs.sector_half_width = HALF_WIDTH_RESET;
      for (int s = 0; s < NSECT; s++) held[s] = 0;
      scans_done = '0;
      due_results.delete();
    end else begin
      // compare first: a point taken at this edge cannot have its result out yet
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $error("result with no scan pending: scan_number %0d", out_data.scan_number);
          errors_seen++;
        end else begin
          want = due_results.pop_front();
          errors_seen += field_differs("front_range", want.front_range, out_data.front_range)
                       + field_differs("rear_range", want.rear_range, out_data.rear_range)
                       + field_differs("left_range", want.left_range, out_data.left_range)
                       + field_differs("right_range", want.right_range, out_data.right_range)
                       + field_differs("sector_found", want.sector_found,
                                       out_data.sector_found)
                       + field_differs("scan_number", want.scan_number, out_data.scan_number);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MIN_DIST:   regs.min_valid_distance = cfg_data;
          REG_MASK_START: regs.mask_start_angle   = cfg_data;
          REG_MASK_END:   regs.mask_end_angle     = cfg_data;
          REG_MASK_MAX:   regs.mask_max_distance  = cfg_data;
          REG_FRONT_CTR:  regs.front_center_angle = cfg_data;
          REG_HALF_WIDTH: regs.sector_half_width  = cfg_data[14:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) bin_point(in_data);
    end
    mismatches  <= errors_seen;
    outstanding <= due_results.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the four-sector robust range testbench: clock, reset, point and
// register stimulus, result back-pressure and the verdict.
// Depends on l4s_pkg, lidar_four_sector_robust_range and l4s_range_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import l4s_pkg::*;

  // Indexes beyond the register file; writes to them must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int PHASES        = 10;
  localparam int PHASE_POINTS  = 58;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 8;
  localparam int LIMIT_NS      = 5_000_000;

  typedef enum int {PICK_LOW, PICK_HIGH, PICK_MIXED} pick_mode_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  point_t               in_data;
  logic                 out_valid;
  logic                 out_stall;
  result_t              out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;
  int                   mismatches;
  int                   outstanding;
  int                   points_sent;

  lidar_four_sector_robust_range dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  l4s_range_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case a transaction never completes
  initial begin
    #(LIMIT_NS);
    $display("FAILURE");
    $finish;
  end

  // Result back-pressure: mostly short bursts of stall, now and then a long
  // hold, and some long stretches with no stall at all.
  initial begin
    int roll;
    int span;
    out_stall <= 1'b0;
    forever begin
      roll = $urandom_range(0, 19);
      if (roll < 8) begin
        out_stall <= 1'b0;
        span = $urandom_range(1, 20);
      end else if (roll < 16) begin
        out_stall <= 1'b1;
        span = $urandom_range(1, 3);
      end else if (roll < 18) begin
        out_stall <= 1'b0;
        span = $urandom_range(80, 150);
      end else begin
        out_stall <= 1'b1;
        span = $urandom_range(20, 60);
      end
      repeat (span) @(posedge clk);
    end
  end

  // Idle cycles after a point: mostly none or a few, rarely a long pause.
  // A steady scan keeps in_valid high throughout.
  function automatic int gap_len(bit steady);
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // Present one point and hold it until the block takes it. in_valid stays
  // high when no gap follows, so the next point goes out back to back.
  task automatic send_point(logic [15:0] ang, logic [15:0] range_mm, logic last, int gap);
    point_t p;
    p.point_angle    = ang;
    p.point_distance = range_mm;
    p.scan_last      = last;
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait for every scan result to drain, then allow the
  // pipeline time to finish any point that produces no result.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high so writes go out back to back; the caller drops it
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_value(pick_mode_t mode, int lo, int hi,
                                             int t_lo, int t_hi);
    int roll;
    if (mode == PICK_LOW) return 16'(lo);
    if (mode == PICK_HIGH) return 16'(hi);
    roll = $urandom_range(0, 9);
    if (roll == 0) return 16'(lo);
    if (roll == 1) return 16'(hi);
    if (roll == 2) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(t_lo, t_hi));
  endfunction

  // Rewrite the whole register file. A full random mask end may fall below
  // the start, which gives the empty (inverted) window.
  task automatic configure(pick_mode_t mode);
    logic [15:0] start;
    write_register(REG_MIN_DIST, pick_value(mode, 0, 65535, 0, 400));
    start = pick_value(mode, 0, 36000, 0, 35999);
    write_register(REG_MASK_START, start);
    write_register(REG_MASK_END, pick_value(mode, 0, 36000, start, start + 3000));
    write_register(REG_MASK_MAX, pick_value(mode, 0, 65535, 0, 1500));
    write_register(REG_FRONT_CTR, pick_value(mode, 0, 35999, 0, 35999));
    write_register(REG_HALF_WIDTH, pick_value(mode, 0, 65535, 100, 18000));
    write_register($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                   16'($urandom_range(0, 65535)));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] random_angle();
    // a tenth of the angles are drawn from the full 16-bit range, some past a full turn, to exercise the wrap
    if ($urandom_range(0, 9) == 0) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(0, 35999));
  endfunction

  function automatic logic [15:0] random_distance();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return 16'd0;
    if (roll == 1) return 16'hFFFF;
    if (roll == 2) return 16'($urandom_range(0, 65535));
    if (roll < 8) return 16'($urandom_range(1, 600));
    return 16'($urandom_range(1, 4000));
  endfunction

  // One scan: a run of points closed by a last-of-scan point
  task automatic send_scan();
    int  len;
    int  roll;
    bit  steady;
    roll = $urandom_range(0, 9);
    if (roll == 0) len = 1;
    else if (roll < 3) len = $urandom_range(9, 20);
    else len = $urandom_range(2, 8);
    steady = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < len; k++)
      send_point(random_angle(), random_distance(), k == len - 1, gap_len(steady));
    points_sent += len;
  endtask

  initial begin
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: front centred on 0, half width 30 degrees, no mask.
    // Zero distance is dropped; front takes both boundaries and the wrap
    // at 35999; an angle of 65535 folds into the right sector; front ends
    // with more than three points, rear with one.
    send_point(16'd0, 16'd0, 1'b0, gap_len(1'b0));
    send_point(16'd0, 16'd1, 1'b0, gap_len(1'b0));
    send_point(16'd3000, 16'hFFFF, 1'b0, gap_len(1'b0));
    send_point(16'd3001, 16'd500, 1'b0, gap_len(1'b0));
    send_point(16'd33000, 16'd700, 1'b0, gap_len(1'b0));
    send_point(16'd35999, 16'd200, 1'b0, gap_len(1'b0));
    send_point(16'hFFFF, 16'd300, 1'b0, gap_len(1'b0));
    send_point(16'd18000, 16'd400, 1'b1, gap_len(1'b0));
    // A scan whose only point is dropped: nothing found
    send_point(16'd9000, 16'd0, 1'b1, gap_len(1'b0));
    settle();

    // Narrow sectors (half width 0 clamps to 1 degree), front centre past a
    // full turn, a mask window around the left centre and a minimum range.
    // Hit the spare indexes too.
    write_register(REG_MIN_DIST, 16'd10);
    write_register(REG_MASK_START, 16'd2500);
    write_register(REG_MASK_END, 16'd2700);
    write_register(REG_MASK_MAX, 16'd500);
    write_register(REG_FRONT_CTR, 16'hFFFF);
    write_register(REG_HALF_WIDTH, 16'd0);
    write_register(REG_SPARE_LO, 16'h1234);
    write_register(REG_SPARE_HI, 16'hFFFF);
    cfg_valid <= 1'b0;
    send_point(16'd2535, 16'd500, 1'b0, gap_len(1'b0));
    send_point(16'd2535, 16'd501, 1'b0, gap_len(1'b0));
    send_point(16'd2535, 16'd9, 1'b0, gap_len(1'b0));
    send_point(16'd2435, 16'd10, 1'b0, gap_len(1'b0));
    send_point(16'd2636, 16'd800, 1'b0, gap_len(1'b0));
    send_point(16'd29535, 16'hFFFF, 1'b1, gap_len(1'b0));
    settle();

    // Inverted mask window masks nothing; an oversized half width clamps
    // to 180 degrees so every sector takes every point, the exact opposite
    // angle included.
    write_register(REG_MIN_DIST, 16'd0);
    write_register(REG_MASK_START, 16'd3000);
    write_register(REG_MASK_END, 16'd2000);
    write_register(REG_MASK_MAX, 16'hFFFF);
    write_register(REG_FRONT_CTR, 16'd0);
    write_register(REG_HALF_WIDTH, 16'hFFFF);
    cfg_valid <= 1'b0;
    send_point(16'd2500, 16'd5, 1'b0, gap_len(1'b0));
    send_point(16'd18000, 16'd6, 1'b0, gap_len(1'b0));
    send_point(16'd0, 16'd7, 1'b1, gap_len(1'b0));

    // Random phases: drain, rewrite the registers (all low extremes first,
    // then all high, then mixed), then a run of scans.
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      configure(phase == 0 ? PICK_LOW : (phase == 1 ? PICK_HIGH : PICK_MIXED));
      points_sent = 0;
      while (points_sent < PHASE_POINTS) send_scan();
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/l4s_pkg.sv
sv/l4s_filter.sv
sv/l4s_rank.sv
sv/lidar_four_sector_robust_range.sv
sv/l4s_checker.sv
tb/sv/l4s_range_checker.sv
tb/sv/testbench.sv
